// File: rtl/chacha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types, constants and the quarter-round step for the keystream source.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int WORD_W       = 32;
  localparam int BYTE_COUNT_W = 7;
  localparam int BLOCK_BYTES  = 64;
  localparam int BLOCK_WORDS  = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [WORD_W-1:0] COUNTER_LIMIT = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] COUNTER_START = 32'h0000_0001;

  localparam logic [3:0][WORD_W-1:0] SIGMA = {
    32'h6B20_6574, 32'h7962_2D32, 32'h3320_646E, 32'h6170_7865
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_0    = 3'd0,
    REG_KEY_1    = 3'd1,
    REG_KEY_2    = 3'd2,
    REG_KEY_3    = 3'd3,
    REG_NONCE_LO = 3'd4,
    REG_NONCE_HI = 3'd5
  } cfg_reg_e;

  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] word_block_t;

  typedef struct packed {
    logic [7:0][WORD_W-1:0] key;
    logic [2:0][WORD_W-1:0] nonce;
  } cfg_words_t;

  typedef struct packed {
    logic [BYTE_COUNT_W-1:0] count;
  } req_t;

  typedef struct packed {
    logic done;
    logic at_limit;
  } core_stat_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  // One add-xor-rotate step of all four quarter-rounds of a column or diagonal round.
  function automatic word_block_t qr_step(input word_block_t w, input logic [1:0] step,
                                          input logic diag);
    word_block_t res;
    logic [1:0]  l;
    logic [3:0]  ia;
    logic [3:0]  ib;
    logic [3:0]  ic;
    logic [3:0]  id;
    logic [WORD_W-1:0] s;
    res = w;
    for (int lane = 0; lane < 4; lane++) begin
      l  = 2'(lane);
      ia = {2'b00, l};
      ib = {2'b01, 2'(l + {1'b0, diag})};
      ic = {2'b10, 2'(l + {diag, 1'b0})};
      id = {2'b11, 2'(l + {diag, diag})};
      case (step)
        2'd0: begin
          s       = w[ia] + w[ib];
          res[ia] = s;
          res[id] = rotl(w[id] ^ s, 16);
        end
        2'd1: begin
          s       = w[ic] + w[id];
          res[ic] = s;
          res[ib] = rotl(w[ib] ^ s, 12);
        end
        2'd2: begin
          s       = w[ia] + w[ib];
          res[ia] = s;
          res[id] = rotl(w[id] ^ s, 8);
        end
        default: begin
          s       = w[ic] + w[id];
          res[ic] = s;
          res[ib] = rotl(w[ib] ^ s, 7);
        end
      endcase
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/chacha_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chacha_ifs
// Valid/ready channels for byte requests and keystream bytes.
// ----------------------------------------------------------------------------
interface chacha_req_if import chacha_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BYTE_COUNT_W-1:0] byte_count;

  modport source (output valid, output byte_count, input ready);
  modport sink   (input valid, input byte_count, output ready);
endinterface

interface chacha_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       last;
  logic       counter_at_limit;

  modport source (output valid, output key_byte, output last, output counter_at_limit,
                  input ready);
  modport sink   (input valid, input key_byte, input last, input counter_at_limit,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/chacha_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chacha_front
// Request intake: drop empty requests, clamp oversize ones, queue the rest.
// ----------------------------------------------------------------------------
module chacha_front import chacha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  chacha_req_if.sink    req,
  output logic          q_valid,
  output req_t          q_req,
  input  wire logic     q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;
  req_t             clamped;

  assign req.ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready && (req.byte_count != '0);
  assign pop       = q_pop && (fill != '0);
  assign q_valid   = (fill != '0);
  assign q_req     = slots[rd_ptr];

  always_comb begin
    clamped.count = (req.byte_count > BYTE_COUNT_W'(BLOCK_BYTES)) ?
                    BYTE_COUNT_W'(BLOCK_BYTES) : req.byte_count;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/chacha_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chacha_core
// Block generator: one add-xor-rotate step of four quarter-rounds per cycle,
// then the feed-forward add. Holds the block counter and the finished block.
// ----------------------------------------------------------------------------
module chacha_core import chacha_pkg::*; #(
  parameter int ROUND_COUNT = 20
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_words_t cfg_words,
  input  wire logic       reload,
  input  wire logic       start,
  output core_stat_t      stat,
  output word_block_t     block
);

  localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
  localparam int DR_W          = $clog2(DOUBLE_ROUNDS + 1);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } core_state_t;

  core_state_t       state;
  word_block_t       work;
  word_block_t       init;
  logic [WORD_W-1:0] block_counter;
  logic [1:0]        step;
  logic              diag;
  logic [DR_W-1:0]   dround;

  always_comb begin
    init[3:0]   = SIGMA;
    init[11:4]  = cfg_words.key;
    init[12]    = block_counter;
    init[15:13] = cfg_words.nonce;
  end

  assign stat.done     = (state == C_ADD);
  assign stat.at_limit = (block_counter == COUNTER_LIMIT);
  assign block         = work;

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          work <= init;
        end
      end
      C_ROUND: begin
        work <= qr_step(work, step, diag);
      end
      C_ADD: begin
        for (int i = 0; i < BLOCK_WORDS; i++) begin
          work[i] <= work[i] + init[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= C_IDLE;
      step          <= '0;
      diag          <= 1'b0;
      dround        <= '0;
      block_counter <= COUNTER_START;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            state  <= C_ROUND;
            step   <= '0;
            diag   <= 1'b0;
            dround <= '0;
          end
        end
        C_ROUND: begin
          step <= step + 1'b1;
          if (step == 2'd3) begin
            diag <= !diag;
            if (diag) begin
              dround <= dround + 1'b1;
              if (dround == DR_W'(DOUBLE_ROUNDS - 1)) begin
                state <= C_ADD;
              end
            end
          end
        end
        C_ADD: begin
          state <= C_IDLE;
          if (block_counter != COUNTER_LIMIT) begin
            block_counter <= block_counter + 1'b1;
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
      if (reload) begin
        block_counter <= COUNTER_START;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/chacha_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chacha_emit
// Byte sequencer: pop a request, emit its bytes from the block buffer one per
// transfer, and ask the core for a new block when the buffer runs dry.
// ----------------------------------------------------------------------------
module chacha_emit import chacha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire req_t        q_req,
  output logic             q_pop,
  input  wire logic        reload,
  output logic             start,
  input  wire core_stat_t  stat,
  input  wire word_block_t block,
  chacha_byte_if.source    ks
);

  typedef enum logic [1:0] {
    E_RUN  = 2'b01,
    E_WAIT = 2'b10
  } emit_state_t;

  emit_state_t             state;
  logic                    req_active;
  logic [BYTE_COUNT_W-1:0] req_rem;
  logic [BYTE_COUNT_W-1:0] bytes_left;
  logic [BYTE_COUNT_W-1:0] pos_full;
  logic [5:0]              pos;
  logic [WORD_W-1:0]       word;
  logic                    emit;
  logic                    out_valid;
  logic [7:0]              key_byte;
  logic                    last;
  logic                    at_limit;

  assign pos_full = BYTE_COUNT_W'(BLOCK_BYTES) - bytes_left;
  assign pos      = pos_full[5:0];
  assign word     = block[pos[5:2]];

  assign q_pop = !req_active && q_valid;
  assign start = (state == E_RUN) && req_active && (bytes_left == '0);
  assign emit  = (state == E_RUN) && req_active && (bytes_left != '0) &&
                 (!out_valid || ks.ready);

  assign ks.valid            = out_valid;
  assign ks.key_byte         = key_byte;
  assign ks.last             = last;
  assign ks.counter_at_limit = at_limit;

  always_ff @(posedge clk) begin
    if (emit) begin
      key_byte <= word[{pos[1:0], 3'b000} +: 8];
      last     <= (req_rem == BYTE_COUNT_W'(1));
      at_limit <= stat.at_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= E_RUN;
      req_active <= 1'b0;
      req_rem    <= '0;
      bytes_left <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ks.ready && !emit) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid  <= 1'b1;
        bytes_left <= bytes_left - 1'b1;
        req_rem    <= req_rem - 1'b1;
        if (req_rem == BYTE_COUNT_W'(1)) begin
          req_active <= 1'b0;
        end
      end
      if (q_pop) begin
        req_active <= 1'b1;
        req_rem    <= q_req.count;
      end
      case (state)
        E_RUN: begin
          if (start) begin
            state <= E_WAIT;
          end
        end
        E_WAIT: begin
          if (stat.done) begin
            bytes_left <= BYTE_COUNT_W'(BLOCK_BYTES);
            state      <= E_RUN;
          end
        end
        default: begin
          state <= E_RUN;
        end
      endcase
      if (reload) begin
        bytes_left <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/chacha20_keystream_byte_source.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_keystream_byte_source
// ChaCha20 (IETF layout) keystream source: requests of 1 to 64 bytes in,
// keystream bytes out little-endian with a last flag per request.
//
//   channel  dir  width  payload
//   req      in   7      byte_count (0 dropped, above 64 clamped to 64)
//   ks       out  10     key_byte, last, counter_at_limit
//   cfg      in   3+64   cfg_index, cfg_data (key words, nonce words)
//
// A request is popped from the queue before its bytes go out. An empty
// buffer first has the core build a block: one quarter-round step per
// cycle in the shared round unit, then one add.
// A two-entry request queue takes new requests while bytes are still going out.
// The ks output register holds a byte until its transfer; a stall there
// stalls the sequencer only. Reset: counter 1, buffer empty, keys zero.
// ----------------------------------------------------------------------------
module chacha20_keystream_byte_source import chacha_pkg::*; #(
  parameter int ROUND_COUNT = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  chacha_req_if.sink                  req,
  chacha_byte_if.source               ks
);

  logic [CFG_DATA_W-1:0] key_part_0;
  logic [CFG_DATA_W-1:0] key_part_1;
  logic [CFG_DATA_W-1:0] key_part_2;
  logic [CFG_DATA_W-1:0] key_part_3;
  logic [CFG_DATA_W-1:0] nonce_low_part;
  logic [WORD_W-1:0]     nonce_high_part;
  logic                  reload;
  cfg_words_t            cfg_words;
  logic                  q_valid;
  req_t                  q_req;
  logic                  q_pop;
  logic                  start;
  core_stat_t            stat;
  word_block_t           block;

  assign reload = cfg_write && (cfg_index <= REG_NONCE_HI);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_part_0      <= '0;
      key_part_1      <= '0;
      key_part_2      <= '0;
      key_part_3      <= '0;
      nonce_low_part  <= '0;
      nonce_high_part <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        REG_KEY_0:    key_part_0      <= cfg_data;
        REG_KEY_1:    key_part_1      <= cfg_data;
        REG_KEY_2:    key_part_2      <= cfg_data;
        REG_KEY_3:    key_part_3      <= cfg_data;
        REG_NONCE_LO: nonce_low_part  <= cfg_data;
        REG_NONCE_HI: nonce_high_part <= cfg_data[WORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_words.key   = {key_part_3, key_part_2, key_part_1, key_part_0};
    cfg_words.nonce = {nonce_high_part, nonce_low_part};
  end

  chacha_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop)
  );

  chacha_core #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_words (cfg_words),
    .reload    (reload),
    .start     (start),
    .stat      (stat),
    .block     (block)
  );

  chacha_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop),
    .reload  (reload),
    .start   (start),
    .stat    (stat),
    .block   (block),
    .ks      (ks)
  );

endmodule
`default_nettype wire
